// ===== design/imu_angle_frame_parser_top_assert.svh =====
// Assertion macros shared by the angle frame parser modules.
`ifndef IMU_ANGLE_FRAME_PARSER_TOP_ASSERT_SVH
`define IMU_ANGLE_FRAME_PARSER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IMU_AFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define IMU_AFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/imu_afp_pkg.sv =====
// Package with the types and constants of the angle frame parser.
package imu_afp_pkg;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAngle = 8'h53;

  localparam int unsigned PosW = 4;
  localparam logic [PosW-1:0] FrameLen   = 4'd11;
  localparam logic [PosW-1:0] LastPos    = 4'd10;
  localparam logic [PosW-1:0] AngleFirst = 4'd2;
  localparam logic [PosW-1:0] AngleLast  = 4'd7;
  localparam int unsigned AngleBytes = 6;
  localparam int unsigned AngleIdxW  = $clog2(AngleBytes);

  // Scaling: centideg = raw * 18000 / 32768, truncated toward zero.
  localparam logic signed [15:0] ScaleNum   = 16'sd18000;
  localparam int unsigned        ScaleShift = 15;
  localparam logic signed [31:0] ScaleBias  = 32'sd32767;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } raw_angles_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== design/imu_afp_front.sv =====
// Front end: byte acceptance, frame sync, running checksum and angle capture.
`include "imu_angle_frame_parser_top_assert.svh"

module imu_afp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_acc_i,
  input  logic [7:0]                rx_byte_i,
  output logic                      push_o,
  output imu_afp_pkg::raw_angles_t  push_data_o
);
  import imu_afp_pkg::*;

  logic [PosW-1:0]      pos_q, pos_d;
  logic [7:0]           sum_q, sum_d;
  logic [7:0]           angle_bytes_q [AngleBytes];
  logic                 angle_wr;
  logic [AngleIdxW-1:0] angle_idx;
  logic                 is_hdr;

  assign is_hdr    = (rx_byte_i == HdrByte);
  assign angle_wr  = in_acc_i && (pos_q >= AngleFirst) && (pos_q <= AngleLast);
  assign angle_idx = AngleIdxW'(pos_q - AngleFirst);

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    push_o = 1'b0;
    if (in_acc_i) begin
      priority if (pos_q == '0 || pos_q >= FrameLen) begin
        pos_d = '0;
        if (is_hdr) begin
          pos_d = PosW'(1);
          sum_d = HdrByte;
        end
      end else if (pos_q == PosW'(1) && rx_byte_i != TypeAngle) begin
        // resync on a new header, otherwise drop back to idle
        if (is_hdr) begin
          sum_d = HdrByte;
        end else begin
          pos_d = '0;
        end
      end else if (pos_q != LastPos) begin
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + PosW'(1);
      end else begin
        pos_d = '0;
        if (sum_q == rx_byte_i) begin
          push_o = 1'b1;
        end else if (is_hdr) begin
          pos_d = PosW'(1);
          sum_d = HdrByte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (angle_wr) begin
      angle_bytes_q[angle_idx] <= rx_byte_i;
    end
  end

  assign push_data_o.roll  = {angle_bytes_q[1], angle_bytes_q[0]};
  assign push_data_o.pitch = {angle_bytes_q[3], angle_bytes_q[2]};
  assign push_data_o.yaw   = {angle_bytes_q[5], angle_bytes_q[4]};

  `IMU_AFP_ASSERT_ALWAYS(a_pos_in_frame, !rst_ni || pos_q < FrameLen, "byte position left the frame")
  `IMU_AFP_ASSERT(a_push_at_end, push_o |-> (in_acc_i && pos_q == LastPos),
                  "frame pushed before its checksum byte")
  `IMU_AFP_ASSERT(a_idle_drop, (in_acc_i && pos_q == '0 && !is_hdr) |=> (pos_q == '0),
                  "idle parser left idle on a non-header byte")
  `IMU_AFP_ASSERT(a_hdr_sum, (in_acc_i && is_hdr && pos_d == PosW'(1)) |=> (sum_q == HdrByte),
                  "new frame did not seed the checksum with the header")

endmodule

// ===== design/imu_afp_fifo.sv =====
// Short queue of raw angle sets between the front and back ends.
`include "imu_angle_frame_parser_top_assert.svh"

module imu_afp_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  imu_afp_pkg::raw_angles_t   push_data_i,
  input  logic                       pop_i,
  output imu_afp_pkg::raw_angles_t   pop_data_o,
  output imu_afp_pkg::fifo_status_t  status_o
);
  import imu_afp_pkg::*;

  raw_angles_t         entries_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;

  function automatic logic [FifoPtrW-1:0] ptr_next(input logic [FifoPtrW-1:0] p);
    logic [FifoPtrW-1:0] n;
    if (p == FifoPtrW'(FifoDepth - 1)) begin
      n = '0;
    end else begin
      n = p + FifoPtrW'(1);
    end
    return n;
  endfunction

  assign status_o.full  = (count_q == FifoCntW'(FifoDepth));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FifoCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  `IMU_AFP_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= FifoCntW'(FifoDepth),
                         "queue count above its depth")
  `IMU_AFP_ASSERT(a_no_overflow, push_i |-> !status_o.full, "push into a full queue")
  `IMU_AFP_ASSERT(a_no_underflow, pop_i |-> !status_o.empty, "pop from an empty queue")
  `IMU_AFP_ASSERT(a_count_up, (push_i && !pop_i) |=> (count_q == $past(count_q) + FifoCntW'(1)),
                  "queue count did not advance on push")

endmodule

// ===== design/imu_afp_back.sv =====
// Back end: angle scaling and the output register.
module imu_afp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  imu_afp_pkg::raw_angles_t   pop_data_i,
  input  imu_afp_pkg::fifo_status_t  status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [15:0]         roll_centideg_o,
  output logic signed [15:0]         pitch_centideg_o,
  output logic signed [15:0]         yaw_centideg_o
);
  import imu_afp_pkg::*;

  logic               out_valid_q;
  logic signed [15:0] roll_q, pitch_q, yaw_q;

  // raw * 18000 / 32768, truncated toward zero
  function automatic logic signed [15:0] scale_angle(input logic signed [15:0] raw);
    logic signed [31:0] prod;
    logic signed [31:0] adj;
    prod = 32'(raw) * 32'(ScaleNum);
    adj  = prod[31] ? (prod + ScaleBias) : prod;
    return 16'(adj >>> ScaleShift);
  endfunction

  assign pop_o = !status_i.empty && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      roll_q  <= scale_angle(pop_data_i.roll);
      pitch_q <= scale_angle(pop_data_i.pitch);
      yaw_q   <= scale_angle(pop_data_i.yaw);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign roll_centideg_o  = roll_q;
  assign pitch_centideg_o = pitch_q;
  assign yaw_centideg_o   = yaw_q;

endmodule

// ===== design/imu_angle_frame_parser_top.sv =====
// Top level of the IMU angle frame parser.
//
// The parser takes one serial byte per transaction and hunts for 11-byte
// angle frames: header 0x55, type 0x53, roll/pitch/yaw as little-endian
// signed 16-bit values, two unused bytes and an 8-bit sum of bytes 0..9.
// A frame whose checksum matches gives one output transaction carrying the
// three angles in hundredths of a degree (raw * 18000 / 32768, truncated
// toward zero); bad frames give nothing. A wrong type byte or a failed
// checksum byte that equals 0x55 is taken as the header of a new frame.
// Rate: one byte per clock cycle while in_stall_o is low. The front end
// settles sync state and checksum for each byte as it is taken and pushes
// a finished raw angle set into a two-entry queue; the back end scales the
// three angles (one 16x16 multiply each) straight into the output register.
// A good frame reaches the output through the queue and then the output register.
// in_stall_o rises only while the queue is full, which needs the output
// to stay stalled on one frame while two further frames complete.
module imu_angle_frame_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_centideg_o,
  output logic signed [15:0] pitch_centideg_o,
  output logic signed [15:0] yaw_centideg_o
);
  import imu_afp_pkg::*;

  logic         in_acc;
  logic         push;
  logic         pop;
  raw_angles_t  push_data;
  raw_angles_t  pop_data;
  fifo_status_t fifo_status;

  // Hold input bytes only while the queue has no room for a finished frame.
  assign in_stall_o = fifo_status.full;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Front end: sync, checksum and raw angle capture.
  imu_afp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue decouples frame detection from output backpressure.
  imu_afp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_status)
  );

  // Back end: scale and present the result.
  imu_afp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_data_i       (pop_data),
    .status_i         (fifo_status),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .roll_centideg_o  (roll_centideg_o),
    .pitch_centideg_o (pitch_centideg_o),
    .yaw_centideg_o   (yaw_centideg_o)
  );

endmodule
